### src/hspg_pkg.sv
// Package for the halo stick page generator: widths, codes, register indexes
// and the item word handed from the page stages to the result sequencer.
// No dependencies.
`default_nettype none
package hspg_pkg;

  localparam int MaxHaloColsDef = 16;
  localparam int RowW  = 24;
  localparam int GW    = 25;
  localparam int HtW   = 14;
  localparam int SpbW  = 22;
  localparam int PageW = 32;
  localparam int WaitW = 25;
  localparam int DataW = 32;

  localparam int FlagFirst = 0;
  localparam int FlagLast  = 1;
  localparam int FlagRight = 2;
  localparam int FlagZeros = 3;

  localparam logic KIND_STICK  = 1'b0;
  localparam logic KIND_SIGNAL = 1'b1;

  typedef enum logic [1:0] {
    SRC_TENSOR = 2'd0,
    SRC_HALO   = 2'd1,
    SRC_ZERO   = 2'd2
  } source_t;

  typedef enum logic [2:0] {
    REG_INPUT_HEIGHT = 3'd0,
    REG_HALO_ROWS    = 3'd1,
    REG_ROW_STICKS   = 3'd2,
    REG_HALO_COLS    = 3'd3,
    REG_BOTTOM_BASE  = 3'd4,
    REG_BATCH_FRAMES = 3'd5,
    REG_START_ROW    = 3'd6,
    REG_POSITION     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [1:0]       src;
    logic [PageW-1:0] rowpage;
    logic             sig;
    logic [WaitW-1:0] cnt;
  } item_t;

endpackage
`default_nettype wire

### src/halo_stick_page_generator.sv
// Halo stick page generator top level: configuration registers, input stage,
// two divider pipelines, page stages and result sequencer.
// Depends on hspg_pkg, hspg_div, hspg_page, hspg_expand.
//
//   channel   handshake          word
//   input     start / busy       row_offset, final_row
//   result    strobe             kind, source, page, wait_count, last
//   config    wr_en              wr_index, wr_data
//
// The accepting edge loads the input stage; 25 divider stages (one quotient
// bit each), three page stages and the sequencer load follow, and the output
// register then raises strobe for the first result. Results leave one per
// cycle while the sequencer expands an item; busy rises while it is full and
// the whole pipeline holds. Reset clears all valid bits and the configuration
// registers.
`default_nettype none
module halo_stick_page_generator #(
  parameter int MAX_HALO_COLS = hspg_pkg::MaxHaloColsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hspg_pkg::RowW-1:0]     row_offset,
  input  wire logic                          final_row,
  input  wire logic                          wr_en,
  input  wire logic [2:0]                    wr_index,
  input  wire logic [hspg_pkg::DataW-1:0]    wr_data,
  output logic                               strobe,
  output logic                               kind,
  output logic [1:0]                         source,
  output logic [hspg_pkg::PageW-1:0]         page,
  output logic [hspg_pkg::WaitW-1:0]         wait_count,
  output logic                               last
);

  localparam int KW = $clog2(MAX_HALO_COLS + 1);

  logic [12:0] input_height;
  logic [7:0]  halo_rows;
  logic [15:0] row_sticks;
  logic [4:0]  halo_cols;
  logic [31:0] bottom_halo_base;
  logic [7:0]  batch_frames;
  logic [23:0] start_row;
  logic [3:0]  position_flags;

  logic [hspg_pkg::HtW-1:0]  htot;
  logic [hspg_pkg::HtW-1:0]  htot_c;
  logic [hspg_pkg::SpbW-1:0] spb;
  logic [21:0]               spb_prod;
  logic [KW-1:0]             hcq;

  logic                      en;
  logic                      s0_v;
  logic [hspg_pkg::GW-1:0]   s0_g;
  logic [hspg_pkg::WaitW-1:0] s0_cnt;
  logic                      s0_fin;

  logic                      a_v;
  logic [hspg_pkg::GW-1:0]   a_quo;
  logic [hspg_pkg::HtW-1:0]  a_rem;
  logic [hspg_pkg::WaitW+hspg_pkg::GW-1:0] a_tag;
  logic                      b_v;
  logic [hspg_pkg::GW-1:0]   b_quo;
  logic [hspg_pkg::SpbW-1:0] b_rem;
  logic                      b_tag;

  logic                      p_v;
  hspg_pkg::item_t           p_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_height     <= 13'd1;
      halo_rows        <= '0;
      row_sticks       <= 16'd1;
      halo_cols        <= '0;
      bottom_halo_base <= '0;
      batch_frames     <= 8'd1;
      start_row        <= '0;
      position_flags   <= '0;
    end else if (wr_en) begin
      case (hspg_pkg::reg_index_t'(wr_index))
        hspg_pkg::REG_INPUT_HEIGHT: input_height     <= wr_data[12:0];
        hspg_pkg::REG_HALO_ROWS:    halo_rows        <= wr_data[7:0];
        hspg_pkg::REG_ROW_STICKS:   row_sticks       <= wr_data[15:0];
        hspg_pkg::REG_HALO_COLS:    halo_cols        <= wr_data[4:0];
        hspg_pkg::REG_BOTTOM_BASE:  bottom_halo_base <= wr_data;
        hspg_pkg::REG_BATCH_FRAMES: batch_frames     <= wr_data[7:0];
        hspg_pkg::REG_START_ROW:    start_row        <= wr_data[23:0];
        hspg_pkg::REG_POSITION:     position_flags   <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  assign htot_c   = hspg_pkg::HtW'(input_height) + {5'd0, halo_rows, 1'b0};
  assign spb_prod = 22'(batch_frames) * 22'(htot_c);

  always_ff @(posedge clk) begin
    htot <= htot_c;
    spb  <= spb_prod;
    if (position_flags[hspg_pkg::FlagLast]) begin
      hcq <= '0;
    end else if (32'(halo_cols) > MAX_HALO_COLS) begin
      hcq <= KW'(MAX_HALO_COLS);
    end else begin
      hcq <= KW'(halo_cols);
    end
  end

  assign busy = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= start;
    end
    if (en) begin
      s0_g   <= hspg_pkg::GW'(start_row) + hspg_pkg::GW'(row_offset);
      s0_cnt <= hspg_pkg::WaitW'(row_offset) + hspg_pkg::WaitW'(1);
      s0_fin <= final_row;
    end
  end

  hspg_div #(
    .NW(hspg_pkg::GW),
    .DW(hspg_pkg::HtW),
    .TW(hspg_pkg::WaitW + hspg_pkg::GW)
  ) u_frame_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_v),
    .dividend (s0_g),
    .divisor  (htot),
    .in_tag   ({s0_cnt, s0_g}),
    .out_valid(a_v),
    .quo      (a_quo),
    .rem      (a_rem),
    .out_tag  (a_tag)
  );

  hspg_div #(
    .NW(hspg_pkg::WaitW),
    .DW(hspg_pkg::SpbW),
    .TW(1)
  ) u_batch_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_v),
    .dividend (s0_cnt),
    .divisor  (spb),
    .in_tag   (s0_fin),
    .out_valid(b_v),
    .quo      (b_quo),
    .rem      (b_rem),
    .out_tag  (b_tag)
  );

  hspg_page u_page (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (a_v && b_v && (b_quo == b_quo)),
    .quo             (a_quo),
    .rem             (a_rem),
    .g               (a_tag[hspg_pkg::GW-1:0]),
    .cnt             (a_tag[hspg_pkg::WaitW+hspg_pkg::GW-1:hspg_pkg::GW]),
    .brem            (b_rem),
    .fin             (b_tag),
    .input_height    (input_height),
    .halo_rows       (halo_rows),
    .row_sticks      (row_sticks),
    .bottom_halo_base(bottom_halo_base),
    .htot            (htot),
    .spb_zero        (spb == '0),
    .first           (position_flags[hspg_pkg::FlagFirst]),
    .out_valid       (p_v),
    .item            (p_item)
  );

  hspg_expand #(
    .KW(KW)
  ) u_expand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_v),
    .item      (p_item),
    .hcq       (hcq),
    .row_sticks(row_sticks),
    .first     (position_flags[hspg_pkg::FlagFirst]),
    .right     (position_flags[hspg_pkg::FlagRight]),
    .zeros     (position_flags[hspg_pkg::FlagZeros]),
    .en        (en),
    .strobe    (strobe),
    .kind      (kind),
    .source    (source),
    .page      (page),
    .wait_count(wait_count),
    .last      (last)
  );

endmodule
`default_nettype wire

### src/hspg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. A zero divisor gives a zero quotient and the low dividend bits as remainder.
// Depends on nothing.
`default_nettype none
module hspg_div #(
  parameter int NW = 25,
  parameter int DW = 14,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_valid,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem,
  output logic [TW-1:0]      out_tag
);

  logic          vld [NW];
  logic [DW-1:0] rm  [NW];
  logic [NW-1:0] dq  [NW];
  logic [TW-1:0] tg  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prm;
    logic [NW-1:0] pdq;
    logic [TW-1:0] ptg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_head
      assign pv  = in_valid;
      assign prm = '0;
      assign pdq = dividend;
      assign ptg = in_tag;
    end else begin : g_body
      assign pv  = vld[i-1];
      assign prm = rm[i-1];
      assign pdq = dq[i-1];
      assign ptg = tg[i-1];
    end

    assign trial = {prm, pdq[NW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign take  = (divisor != '0) && (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= pv;
      end
      if (en) begin
        rm[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
        dq[i] <= {pdq[NW-2:0], take};
        tg[i] <= ptg;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = dq[NW-1];
  assign rem       = rm[NW-1];
  assign out_tag   = tg[NW-1];

endmodule
`default_nettype wire

### src/hspg_page.sv
// Page stages: region of the padded row, row base through two registered
// multiplies, progress signal decision. Depends on hspg_pkg.
`default_nettype none
module hspg_page (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [hspg_pkg::GW-1:0]      quo,
  input  wire logic [hspg_pkg::HtW-1:0]     rem,
  input  wire logic [hspg_pkg::GW-1:0]      g,
  input  wire logic [hspg_pkg::WaitW-1:0]   cnt,
  input  wire logic [hspg_pkg::SpbW-1:0]    brem,
  input  wire logic                         fin,
  input  wire logic [12:0]                  input_height,
  input  wire logic [7:0]                   halo_rows,
  input  wire logic [15:0]                  row_sticks,
  input  wire logic [31:0]                  bottom_halo_base,
  input  wire logic [hspg_pkg::HtW-1:0]     htot,
  input  wire logic                         spb_zero,
  input  wire logic                         first,
  output logic                              out_valid,
  output hspg_pkg::item_t                   item
);

  logic [hspg_pkg::GW-1:0]  hp;
  logic [hspg_pkg::GW-1:0]  t_c;
  logic [hspg_pkg::GW-1:0]  hi;
  logic                     top_c;
  logic                     mid_c;
  logic [hspg_pkg::GW-1:0]  r_c;

  logic                     v1;
  logic [1:0]               src1;
  logic [31:0]              base1;
  logic [12:0]              x1;
  logic [hspg_pkg::GW-1:0]  r1;
  logic [hspg_pkg::GW-1:0]  t1;
  logic                     sig1;
  logic [hspg_pkg::WaitW-1:0] cnt1;

  logic [37:0]              prod2;
  logic                     v2;
  logic [1:0]               src2;
  logic [31:0]              base2;
  logic [31:0]              m2;
  logic                     sig2;
  logic [hspg_pkg::WaitW-1:0] cnt2;

  logic [47:0]              prod3;
  logic                     v3;

  assign hp    = (htot == '0) ? g : hspg_pkg::GW'(rem);
  assign t_c   = (htot == '0) ? '0 : quo;
  assign hi    = hspg_pkg::GW'(halo_rows) + hspg_pkg::GW'(input_height);
  assign top_c = hp < hspg_pkg::GW'(halo_rows);
  assign mid_c = !top_c && (hp < hi);
  assign r_c   = top_c ? hp : (mid_c ? hp - hspg_pkg::GW'(halo_rows) : hp - hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      src1  <= mid_c ? hspg_pkg::SRC_TENSOR : hspg_pkg::SRC_HALO;
      base1 <= (top_c || mid_c) ? 32'd0 : bottom_halo_base;
      x1    <= mid_c ? input_height : 13'(halo_rows);
      r1    <= r_c;
      t1    <= t_c;
      sig1  <= !first && (fin || (!spb_zero && brem == '0));
      cnt1  <= cnt;
    end
  end

  assign prod2 = 38'(t1) * 38'(x1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      src2  <= src1;
      base2 <= base1;
      m2    <= prod2[31:0] + 32'(r1);
      sig2  <= sig1;
      cnt2  <= cnt1;
    end
  end

  assign prod3 = 48'(m2) * 48'(row_sticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      item.src     <= src2;
      item.rowpage <= base2 + prod3[31:0];
      item.sig     <= sig2;
      item.cnt     <= cnt2;
    end
  end

  assign out_valid = v3;

endmodule
`default_nettype wire

### src/hspg_expand.sv
// Result sequencer: turns one item word into its stick reads and progress
// signal, one result a cycle, into registered outputs. Depends on hspg_pkg.
`default_nettype none
module hspg_expand #(
  parameter int KW = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire hspg_pkg::item_t             item,
  input  wire logic [KW-1:0]               hcq,
  input  wire logic [15:0]                 row_sticks,
  input  wire logic                        first,
  input  wire logic                        right,
  input  wire logic                        zeros,
  output logic                             en,
  output logic                             strobe,
  output logic                             kind,
  output logic [1:0]                       source,
  output logic [hspg_pkg::PageW-1:0]       page,
  output logic [hspg_pkg::WaitW-1:0]       wait_count,
  output logic                             last
);

  logic                 fst_pend;
  logic [KW-1:0]        kr;
  logic                 sig_pend;
  hspg_pkg::item_t      hold;

  logic                 emit;
  logic                 is_fst;
  logic                 is_col;
  logic                 is_sig;
  logic [KW-1:0]        kr_next;
  logic                 sig_next;
  logic                 more;
  logic [31:0]          kk;
  logic [31:0]          col;
  logic                 zstick;

  assign emit     = fst_pend || (kr != '0) || sig_pend;
  assign is_fst   = fst_pend;
  assign is_col   = !fst_pend && (kr != '0);
  assign is_sig   = !fst_pend && (kr == '0) && sig_pend;
  assign kr_next  = is_col ? kr - KW'(1) : kr;
  assign sig_next = is_sig ? 1'b0 : sig_pend;
  assign more     = (kr_next != '0) || sig_next;
  assign en       = !emit || !more;

  assign kk     = 32'(KW'(hcq - kr));
  assign col    = is_fst ? (right ? 32'(row_sticks) - 32'd1 : 32'd0)
                         : (right ? kk : 32'(row_sticks) - 32'(hcq) + kk);
  assign zstick = is_fst && zeros;

  always_ff @(posedge clk) begin
    if (rst) begin
      fst_pend <= 1'b0;
      kr       <= '0;
      sig_pend <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      if (en && in_valid) begin
        fst_pend <= first;
        kr       <= hcq;
        sig_pend <= item.sig;
      end else begin
        fst_pend <= 1'b0;
        kr       <= kr_next;
        sig_pend <= sig_next;
      end
      strobe <= emit;
    end
    if (en && in_valid) begin
      hold <= item;
    end
    kind       <= is_sig ? hspg_pkg::KIND_SIGNAL : hspg_pkg::KIND_STICK;
    source     <= (is_sig ? hspg_pkg::SRC_TENSOR : (zstick ? hspg_pkg::SRC_ZERO : hold.src));
    page       <= (is_sig || zstick) ? '0 : hold.rowpage + col;
    wait_count <= is_sig ? hold.cnt : '0;
    last       <= !more;
  end

endmodule
`default_nettype wire

### test/tb_halo_stick_page_generator.sv
// Testbench for halo_stick_page_generator: drives row words through start/busy,
// predicts every stick command and progress signal, and checks each strobed word.
// Depends on hspg_pkg and the halo_stick_page_generator RTL.
module tb_halo_stick_page_generator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [1:0]  source;
    logic [31:0] page;
    logic [24:0] wait_count;
    logic        last;
  } cmd_t;

  typedef struct {
    logic [23:0] row_offset;
    logic        final_row;
    bit          pause;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [23:0] row_offset = '0;
  logic final_row = 1'b0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [31:0] wr_data = '0;
  logic busy, strobe, kind, last;
  logic [1:0] source;
  logic [31:0] page;
  logic [24:0] wait_count;

  halo_stick_page_generator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .row_offset(row_offset),
    .final_row(final_row), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .strobe(strobe), .kind(kind), .source(source), .page(page),
    .wait_count(wait_count), .last(last)
  );

  // shadow registers
  logic [12:0] cfg_height;
  logic [7:0]  cfg_halo_rows;
  logic [15:0] cfg_row_sticks;
  logic [4:0]  cfg_halo_cols;
  logic [31:0] cfg_bottom_base;
  logic [7:0]  cfg_batch;
  logic [23:0] cfg_start_row;
  logic [3:0]  cfg_flags;

  row_t row_q[$];
  cmd_t cmd_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int gap = 0;
  bit feeding = 1'b0;
  bit timed_out = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void locate_stick(input logic [31:0] frame, input logic [31:0] prow,
                                       input logic [31:0] col, output logic [1:0] src,
                                       output logic [31:0] pg);
    logic [31:0] s, hr, ih;
    s = 32'(cfg_row_sticks);
    hr = 32'(cfg_halo_rows);
    ih = 32'(cfg_height);
    if (prow >= hr && prow < hr + ih) begin
      src = hspg_pkg::SRC_TENSOR;
      pg = frame * ih * s + (prow - hr) * s + col;
    end else if (prow < hr) begin
      src = hspg_pkg::SRC_HALO;
      pg = frame * hr * s + prow * s + col;
    end else begin
      src = hspg_pkg::SRC_HALO;
      pg = cfg_bottom_base + frame * hr * s + (prow - hr - ih) * s + col;
    end
  endfunction

  task automatic predict_row(input logic [23:0] off, input logic fin);
    cmd_t c;
    cmd_t out[$];
    logic [31:0] htot, g, frame, prow, hc, col, pg, spb, cnt;
    logic [1:0] src;
    htot = 32'(cfg_height) + 32'(cfg_halo_rows) * 32'd2;
    g = 32'(cfg_start_row) + 32'(off);
    if (htot != 0) begin
      frame = g / htot;
      prow = g % htot;
    end else begin
      frame = 0;
      prow = g;
    end
    if (cfg_flags[hspg_pkg::FlagFirst]) begin
      c = '{hspg_pkg::KIND_STICK, hspg_pkg::SRC_ZERO, 32'd0, 25'd0, 1'b0};
      if (!cfg_flags[hspg_pkg::FlagZeros]) begin
        locate_stick(frame, prow,
                     cfg_flags[hspg_pkg::FlagRight] ? 32'(cfg_row_sticks) - 32'd1 : 32'd0,
                     src, pg);
        c.source = src;
        c.page = pg;
      end
      out.push_back(c);
    end
    if (!cfg_flags[hspg_pkg::FlagLast]) begin
      hc = (32'(cfg_halo_cols) > hspg_pkg::MaxHaloColsDef) ? 32'(hspg_pkg::MaxHaloColsDef)
                                                           : 32'(cfg_halo_cols);
      for (int id = int'(hc); id > 0; id--) begin
        col = cfg_flags[hspg_pkg::FlagRight] ? hc - 32'(id) : 32'(cfg_row_sticks) - 32'(id);
        locate_stick(frame, prow, col, src, pg);
        out.push_back('{hspg_pkg::KIND_STICK, src, pg, 25'd0, 1'b0});
      end
    end
    if (!cfg_flags[hspg_pkg::FlagFirst]) begin
      spb = 32'(cfg_batch) * htot;
      cnt = 32'(off) + 32'd1;
      if (fin || (spb != 0 && cnt % spb == 0))
        out.push_back('{hspg_pkg::KIND_SIGNAL, hspg_pkg::SRC_TENSOR, 32'd0, cnt[24:0], 1'b0});
    end
    if (out.size() > 0) out[out.size() - 1].last = 1'b1;
    foreach (out[i]) cmd_q.push_back(out[i]);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_row(row_offset, final_row);
      if (row_q.size() > 0 && gap == 0 && !row_q[0].pause && $urandom_range(0, 3) != 0) begin
        row_offset <= row_q[0].row_offset;
        final_row <= row_q[0].final_row;
        void'(row_q.pop_front());
      end else begin
        start <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      end
    end else if (!start && feeding && row_q.size() > 0) begin
      if (gap > 0) begin
        gap = gap - 1;
      end else if (!row_q[0].pause || cmd_q.size() == 0) begin
        start <= 1'b1;
        row_offset <= row_q[0].row_offset;
        final_row <= row_q[0].final_row;
        void'(row_q.pop_front());
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_t e;
    if (!rst && strobe) begin
      idle_cycles <= 0;
      if (cmd_q.size() == 0) begin
        $error("unexpected word: kind=%0d source=%0d page=%0h", kind, source, page);
        errors++;
      end else begin
        e = cmd_q.pop_front();
        if (kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, kind); errors++;
        end
        if (source !== e.source) begin
          $error("source expected %0d actual %0d", e.source, source); errors++;
        end
        if (page !== e.page) begin
          $error("page expected %0h actual %0h", e.page, page); errors++;
        end
        if (wait_count !== e.wait_count) begin
          $error("wait_count expected %0d actual %0d", e.wait_count, wait_count); errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last); errors++;
        end
      end
    end else if (!rst && start && !busy) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) timed_out <= 1'b1;
  end

  task automatic write_reg(input hspg_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      hspg_pkg::REG_INPUT_HEIGHT: cfg_height = val[12:0];
      hspg_pkg::REG_HALO_ROWS:    cfg_halo_rows = val[7:0];
      hspg_pkg::REG_ROW_STICKS:   cfg_row_sticks = val[15:0];
      hspg_pkg::REG_HALO_COLS:    cfg_halo_cols = val[4:0];
      hspg_pkg::REG_BOTTOM_BASE:  cfg_bottom_base = val;
      hspg_pkg::REG_BATCH_FRAMES: cfg_batch = val[7:0];
      hspg_pkg::REG_START_ROW:    cfg_start_row = val[23:0];
      default:                    cfg_flags = val[3:0];
    endcase
  endtask

  task automatic add_row(input logic [23:0] off, input logic fin, input bit hold);
    row_t r;
    r.row_offset = off;
    r.final_row = fin;
    r.pause = hold;
    row_q.push_back(r);
  endtask

  // run queued rows, then drain and let the pipeline settle
  task automatic run_phase();
    feeding = 1'b1;
    while ((row_q.size() > 0 || start || cmd_q.size() > 0) && !timed_out) @(posedge clk);
    feeding = 1'b0;
    repeat (80) @(posedge clk);
  endtask

  task automatic configure(input logic [12:0] h, input logic [7:0] hr, input logic [15:0] rs,
                           input logic [4:0] hc, input logic [31:0] bb, input logic [7:0] bf,
                           input logic [23:0] sr, input logic [3:0] fl);
    write_reg(hspg_pkg::REG_INPUT_HEIGHT, 32'(h));
    write_reg(hspg_pkg::REG_HALO_ROWS, 32'(hr));
    write_reg(hspg_pkg::REG_ROW_STICKS, 32'(rs));
    write_reg(hspg_pkg::REG_HALO_COLS, 32'(hc));
    write_reg(hspg_pkg::REG_BOTTOM_BASE, bb);
    write_reg(hspg_pkg::REG_BATCH_FRAMES, 32'(bf));
    write_reg(hspg_pkg::REG_START_ROW, 32'(sr));
    write_reg(hspg_pkg::REG_POSITION, 32'(fl));
  endtask

  task automatic random_rows(input int n);
    logic [31:0] htot;
    htot = 32'(cfg_height) + 32'(cfg_halo_rows) * 32'd2;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: add_row(24'($urandom()), 1'($urandom_range(0, 1)), i == n / 2);
        1: add_row(24'(htot * 32'(cfg_batch) * (32'd1 + 32'($urandom_range(0, 3))) - 32'd1),
                   1'b0, i == n / 2);
        default: add_row(24'($urandom_range(0, 200)), $urandom_range(0, 7) == 0, i == n / 2);
      endcase
    end
  endtask

  initial begin
    cfg_height = 13'd1; cfg_halo_rows = 8'd0; cfg_row_sticks = 16'd1; cfg_halo_cols = 5'd0;
    cfg_bottom_base = 32'd0; cfg_batch = 8'd1; cfg_start_row = 24'd0; cfg_flags = 4'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, field extremes
    add_row(24'd0, 1'b0, 1'b0);
    add_row(24'hFFFFFF, 1'b1, 1'b0);
    add_row(24'h555555, 1'b0, 1'b0);
    run_phase();

    // first chip, oversized halo count, right direction
    configure(13'd5, 8'd2, 16'd40, 5'd31, 32'hFFFF_FFF0, 8'd2, 24'hFFFFFF, 4'b0101);
    for (int i = 0; i < 10; i++) add_row(24'(i), i == 9, 1'b0);
    add_row(24'hAAAAAA, 1'b0, 1'b0);
    run_phase();

    // zero sticks, left direction
    configure(13'd4096, 8'd255, 16'd65535, 5'd16, 32'd100, 8'd255, 24'd0, 4'b1001);
    add_row(24'd0, 1'b0, 1'b0);
    add_row(24'd300, 1'b1, 1'b0);
    run_phase();

    // zero frame height: last, non-first chip with empty rows
    configure(13'd0, 8'd0, 16'd7, 5'd3, 32'd9, 8'd1, 24'd3, 4'b0010);
    add_row(24'd1, 1'b0, 1'b0);
    add_row(24'd2, 1'b1, 1'b0);
    add_row(24'd4, 1'b0, 1'b0);
    run_phase();

    for (int p = 0; p < 8 && !timed_out; p++) begin
      configure(13'($urandom_range(1, 12)), 8'($urandom_range(0, 4)),
                16'($urandom_range(1, 64)), 5'($urandom_range(0, 20)), $urandom(),
                8'($urandom_range(1, 4)),
                (p == 3) ? 24'hFFFFFF : 24'($urandom_range(0, 1000)),
                p[3:0] ^ 4'($urandom_range(0, 15)));
      random_rows(44);
      run_phase();
    end

    if (timed_out || errors != 0) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("TEST FAILED");
    $finish;
  end
endmodule
